@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, operation codes and register indexes used
// by the console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = ROWS * COLS;

  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;
  localparam int KIND_W = 2;

  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

endpackage : tcw_pkg
`default_nettype wire

@@ hw/rtl/tcw_cell_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cell store
// Simple dual-port memory: one write port and one read port with registered
// read data that holds its value when no read is requested.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tcw_cell_ram
`default_nettype wire

@@ hw/rtl/text_console_writer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine with a cursor, a cell store and a sweep sequencer
// for clearing and scrolling the screen.
// ----------------------------------------------------------------------------
// A put, a read or an unused operation passes through the execute state to
// the response state after the input transaction is accepted and loads its
// result there; the next input transaction is taken once the sequencer is
// back in idle. A clear walks the whole cell store through its single write
// port before it loads its result. A newline on the last row moves every row
// up and blanks the bottom row before its result is loaded. The input is not
// ready while an operation is in progress, and a result that is not taken
// holds the sequencer until the output register is free. Cells read back as
// undefined until a clear has been done.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CLR_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // char_code [7:0], cell_index [18:8], zero [23:19]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // kind [1:0]
  input  wire logic [KIND_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // cell_data [15:0], cursor_row [20:16], cursor_col [27:21], zero [31:28]
  output logic      [OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } state_t;

  state_t              state;
  logic [CLR_W-1:0]    fg_colour;
  logic [CLR_W-1:0]    bg_colour;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [ADDR_W-1:0]   row_base;
  logic [ADDR_W-1:0]   sweep_addr;
  logic [KIND_W-1:0]   op_kind;
  logic [CHAR_W-1:0]   op_char;
  logic [ADDR_W-1:0]   op_index;
  logic                rd_hit;

  logic [ADDR_W-1:0]   cur_addr;
  logic [CELL_W-1:0]   space_cell;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;
  logic [CELL_W-1:0]   resp_data;

  assign cur_addr   = row_base + ADDR_W'(cur_col);
  assign space_cell = {bg_colour, fg_colour, SPACE_CODE};
  assign s_tready   = (state == ST_IDLE);
  assign resp_data  = (op_kind == KIND_READ && rd_hit) ? ram_rdata : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_addr;
    ram_wdata = space_cell;
    ram_re    = 1'b0;
    ram_raddr = op_index;
    unique case (state)
      ST_EXEC: begin
        if (op_kind == KIND_PUT && op_char != NEWLINE_CODE) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {bg_colour, fg_colour, op_char};
        end
        if (op_kind == KIND_READ && rd_hit) begin
          ram_re = 1'b1;
        end
      end
      ST_SCROLL: begin
        ram_re    = (sweep_addr < ADDR_W'(NCELLS - COLS));
        ram_raddr = sweep_addr + ADDR_W'(COLS);
        ram_we    = (sweep_addr != '0);
        ram_waddr = sweep_addr - ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_cell_ram #(
    .DEPTH  (NCELLS),
    .WIDTH  (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fg_colour  <= CLR_W'(7);
      bg_colour  <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      row_base   <= '0;
      sweep_addr <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FG_COLOUR: fg_colour <= cfg_data;
          REG_BG_COLOUR: bg_colour <= cfg_data;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_kind  <= s_tuser;
            op_char  <= s_tdata[CHAR_W-1:0];
            op_index <= s_tdata[CHAR_W +: ADDR_W];
            rd_hit   <= (s_tdata[CHAR_W +: ADDR_W] < ADDR_W'(NCELLS));
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RESP;
          if (op_kind == KIND_PUT) begin
            if (op_char == NEWLINE_CODE) begin
              cur_col <= '0;
              if (cur_row == ROW_W'(ROWS - 1)) begin
                sweep_addr <= '0;
                state      <= ST_SCROLL;
              end else begin
                cur_row  <= cur_row + ROW_W'(1);
                row_base <= row_base + ADDR_W'(COLS);
              end
            end else if (cur_col == COL_W'(COLS - 1)) begin
              cur_col <= '0;
              if (cur_row == ROW_W'(ROWS - 1)) begin
                cur_row  <= '0;
                row_base <= '0;
              end else begin
                cur_row  <= cur_row + ROW_W'(1);
                row_base <= row_base + ADDR_W'(COLS);
              end
            end else begin
              cur_col <= cur_col + COL_W'(1);
            end
          end else if (op_kind == KIND_CLEAR) begin
            sweep_addr <= '0;
            state      <= ST_FILL;
          end
        end
        ST_SCROLL: begin
          if (sweep_addr == ADDR_W'(NCELLS - COLS)) begin
            state <= ST_FILL;
          end else begin
            sweep_addr <= sweep_addr + ADDR_W'(1);
          end
        end
        ST_FILL: begin
          if (sweep_addr == ADDR_W'(NCELLS - 1)) begin
            state <= ST_RESP;
          end else begin
            sweep_addr <= sweep_addr + ADDR_W'(1);
          end
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(OUT_DATA_W - CELL_W - ROW_W - COL_W)'(0),
                         cur_col, cur_row, resp_data};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(ROWS)) && (cur_col < COL_W'(COLS)))
    else $error("cursor outside the screen");

  a_row_base: assert property (@(posedge clk) disable iff (rst)
    row_base == ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLS)))
    else $error("row base does not match the cursor row");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < ADDR_W'(NCELLS)))
    else $error("cell write outside the store");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && m_tvalid && !m_tready) |=> (state == ST_RESP))
    else $error("result dropped while the output was stalled");
`endif

endmodule : text_console_writer_unit
`default_nettype wire
